@@ hw/rtl/mrtu_pkg.sv @@
// Shared types, constants and the CRC-16 byte function of the Modbus RTU master framer.
`default_nettype none

package mrtu_pkg;

    localparam int MAX_REGISTERS = 32;
    localparam int WORD_IDX_W    = $clog2(MAX_REGISTERS);

    // Configuration register indexes.
    localparam logic CFG_DEVICE_ID    = 1'b0;
    localparam logic CFG_DECAY_PERIOD = 1'b1;

    // Transaction status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_WRITE_ERR = 2'd1;
    localparam logic [1:0] ST_READ_ERR  = 2'd2;

    // CRC seed and polynomial.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        OP_READ,
        OP_SWRITE,
        OP_MWRITE,
        OP_DATA,
        OP_RXB,
        OP_TXFAIL,
        OP_TIMEOUT,
        OP_TICK
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COLLECT,
        PH_AWAIT_READ,
        PH_AWAIT_WRITE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TX,
        KIND_WORD,
        KIND_STATUS,
        KIND_TOTAL
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TX,
        S_RXB,
        S_WORD_RD,
        S_WORD_EMIT,
        S_STATUS,
        S_DIV,
        S_TOTAL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start;
        logic data_begin;
        logic tx_emit;
        logic rx_take;
        logic bump_wr;
        logic bump_rd;
        logic div_start;
        logic word_emit;
        logic status_emit;
        logic total_emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op    op;
        t_phase phase;
        logic   out_room;
        logic   tx_final;
        logic   rx_final_good;
        logic   rx_has_words;
        logic   word_final;
        logic   div_done;
    } t_stat;

    // One byte of the reflected CRC-16 update.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/modbus_rtu_master_framer.sv @@
// Top level of the Modbus RTU master framer: controller, datapath and ports.
//
// Input channel (i_in_valid/o_in_ready) takes one transaction: a request start,
// a multiple-write data word, a response byte, a link failure, a timeout or a tick.
// Output channel (o_out_valid/i_out_ready) returns transmit bytes, read words,
// a status or an error total, with o_last on the final result of a transaction.
// One transaction is handled at a time; o_in_ready is high only while idle.
// Each transaction is captured from idle and decoded in S_DECODE. A request then
// delivers one byte per cycle while the receiver does not stall (up to nine
// bytes), a response byte is taken in S_RXB, a good read releases each word
// through S_WORD_RD (registered store read) and S_WORD_EMIT and then the status,
// and a tick runs the bit-serial divider for the decay step. Ignored transactions
// and response bytes that complete no frame return to idle. A single output
// register holds the current result; when the receiver stalls the controller
// waits before the next result and takes no new transaction. Synchronous reset
// (i_rst_n low) sets device id 1, decay period 1000, clears the counters and the
// frame state, and empties the output register. The user must write configuration
// (i_cfg_we/i_cfg_index/i_cfg_data) only while idle; the block never checks it.
`default_nettype none

module modbus_rtu_master_framer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_operation,
    input  wire logic [7:0]  i_function_code,
    input  wire logic [15:0] i_register_address,
    input  wire logic [5:0]  i_register_count,
    input  wire logic [15:0] i_write_value,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_tx_byte,
    output logic [15:0]      o_data_word,
    output logic [1:0]       o_status,
    output logic [16:0]      o_error_total,
    output logic             o_last
);

    mrtu_pkg::t_cmd  cmd;
    mrtu_pkg::t_stat stat;

    mrtu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mrtu_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_operation),
        .i_function_code    (i_function_code),
        .i_register_address (i_register_address),
        .i_register_count   (i_register_count),
        .i_write_value      (i_write_value),
        .i_rx_byte          (i_rx_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_kind             (o_kind),
        .o_tx_byte          (o_tx_byte),
        .o_data_word        (o_data_word),
        .o_status           (o_status),
        .o_error_total      (o_error_total),
        .o_last             (o_last)
    );

endmodule

`default_nettype wire

@@ hw/rtl/mrtu_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, used for error decay.
`default_nettype none

module mrtu_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quotient,
    output logic [31:0]      o_remainder
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dvs, n_dvs;
    logic [32:0] shifted;
    logic [33:0] diff;

    // One shift-and-subtract step.
    always_comb begin
        shifted = {r_rem, r_quo[31]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!diff[33]) begin
                n_rem = diff[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = shifted[31:0];
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

@@ hw/rtl/mrtu_ctrl.sv @@
// Controller state machine that sequences each transaction through the datapath.
`default_nettype none

module mrtu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire mrtu_pkg::t_stat i_stat,
    output mrtu_pkg::t_cmd     o_cmd
);

    mrtu_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrtu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            mrtu_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mrtu_pkg::S_DECODE;
                end
            end
            mrtu_pkg::S_DECODE: begin
                n_state = mrtu_pkg::S_IDLE;
                case (i_stat.op)
                    mrtu_pkg::OP_READ, mrtu_pkg::OP_SWRITE, mrtu_pkg::OP_MWRITE: begin
                        if (i_stat.phase == mrtu_pkg::PH_IDLE) begin
                            o_cmd.start = 1'b1;
                            n_state     = mrtu_pkg::S_TX;
                        end
                    end
                    mrtu_pkg::OP_DATA: begin
                        if (i_stat.phase == mrtu_pkg::PH_COLLECT) begin
                            o_cmd.data_begin = 1'b1;
                            n_state          = mrtu_pkg::S_TX;
                        end
                    end
                    mrtu_pkg::OP_RXB: begin
                        if (i_stat.phase == mrtu_pkg::PH_AWAIT_READ ||
                            i_stat.phase == mrtu_pkg::PH_AWAIT_WRITE) begin
                            n_state = mrtu_pkg::S_RXB;
                        end
                    end
                    mrtu_pkg::OP_TXFAIL: begin
                        if (i_stat.phase != mrtu_pkg::PH_IDLE) begin
                            o_cmd.bump_wr = 1'b1;
                            n_state       = mrtu_pkg::S_STATUS;
                        end
                    end
                    mrtu_pkg::OP_TIMEOUT: begin
                        if (i_stat.phase == mrtu_pkg::PH_AWAIT_READ ||
                            i_stat.phase == mrtu_pkg::PH_AWAIT_WRITE) begin
                            o_cmd.bump_rd = 1'b1;
                            n_state       = mrtu_pkg::S_STATUS;
                        end
                    end
                    default: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = mrtu_pkg::S_DIV;
                    end
                endcase
            end
            mrtu_pkg::S_TX: begin
                if (i_stat.out_room) begin
                    o_cmd.tx_emit = 1'b1;
                    if (i_stat.tx_final) begin
                        n_state = mrtu_pkg::S_IDLE;
                    end
                end
            end
            mrtu_pkg::S_RXB: begin
                o_cmd.rx_take = 1'b1;
                if (!i_stat.rx_final_good) begin
                    n_state = mrtu_pkg::S_IDLE;
                end else if (i_stat.rx_has_words) begin
                    n_state = mrtu_pkg::S_WORD_RD;
                end else begin
                    n_state = mrtu_pkg::S_STATUS;
                end
            end
            mrtu_pkg::S_WORD_RD: begin
                n_state = mrtu_pkg::S_WORD_EMIT;
            end
            mrtu_pkg::S_WORD_EMIT: begin
                if (i_stat.out_room) begin
                    o_cmd.word_emit = 1'b1;
                    n_state = i_stat.word_final ? mrtu_pkg::S_STATUS : mrtu_pkg::S_WORD_RD;
                end
            end
            mrtu_pkg::S_STATUS: begin
                if (i_stat.out_room) begin
                    o_cmd.status_emit = 1'b1;
                    n_state           = mrtu_pkg::S_IDLE;
                end
            end
            mrtu_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = mrtu_pkg::S_TOTAL;
                end
            end
            mrtu_pkg::S_TOTAL: begin
                if (i_stat.out_room) begin
                    o_cmd.total_emit = 1'b1;
                    n_state          = mrtu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mrtu_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/mrtu_dp.sv @@
// Datapath: frame state, CRC, response word store, error counters and output register.
`default_nettype none

module mrtu_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mrtu_pkg::t_cmd i_cmd,
    output mrtu_pkg::t_stat    o_stat,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic [2:0]    i_operation,
    input  wire logic [7:0]    i_function_code,
    input  wire logic [15:0]   i_register_address,
    input  wire logic [5:0]    i_register_count,
    input  wire logic [15:0]   i_write_value,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_tx_byte,
    output logic [15:0]        o_data_word,
    output logic [1:0]         o_status,
    output logic [16:0]        o_error_total,
    output logic               o_last
);

    localparam logic [5:0] MAX_CNT = 6'(mrtu_pkg::MAX_REGISTERS);

    // Configuration.
    logic [7:0]  r_device_id;
    logic [31:0] r_decay_period;

    // Latched transaction.
    mrtu_pkg::t_op r_op;
    logic [7:0]  r_in_fc;
    logic [15:0] r_in_addr;
    logic [5:0]  r_in_cnt;
    logic [15:0] r_in_val;
    logic [7:0]  r_in_rb;

    // Frame state.
    mrtu_pkg::t_phase r_phase;
    logic [7:0]  r_act_fc;
    logic [15:0] r_act_addr;
    logic [5:0]  r_act_cnt;
    logic [5:0]  r_wts;
    logic [15:0] r_tx_crc;
    logic [15:0] r_rx_crc;
    logic [6:0]  r_rx_pos;
    logic        r_rx_ok;
    logic [7:0]  r_rx_hi;
    logic [15:0] r_wr_err;
    logic [15:0] r_rd_err;
    logic [31:0] r_elapsed;
    logic [1:0]  r_code;

    // Transmit sequencing.
    logic [3:0]  r_tx_idx;
    logic [3:0]  r_tx_len;
    logic        r_tx_crc_tail;
    logic        r_tx_start;
    logic        r_tx_single;

    // Word release.
    logic [5:0]  r_word_idx;
    logic [15:0] r_rd_data;
    logic [15:0] mem [mrtu_pkg::MAX_REGISTERS];

    // Output register.
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_tx_byte;
    logic [15:0] r_data_word;
    logic [1:0]  r_status;
    logic [16:0] r_total;
    logic        r_last;

    // Divider.
    logic        div_done;
    logic [31:0] div_quo;
    logic [31:0] div_rem;
    logic [31:0] divisor;

    logic [5:0]  cnt_sat;
    logic        out_room;
    logic        tx_is_crc_lo, tx_is_crc_hi;
    logic [7:0]  tx_data_byte;
    logic [7:0]  tx_byte;
    logic        rx_rd;
    logic [6:0]  rx_len;
    logic [6:0]  rx_pos2;
    logic        rx_mid, rx_crclo, rx_final;
    logic [6:0]  rx_off;
    logic        rx_hdr_bad;
    logic        rx_final_good;
    logic [15:0] k_sat;
    logic [15:0] wr_dec, rd_dec;

    assign cnt_sat  = (i_register_count > MAX_CNT) ? MAX_CNT : i_register_count;
    assign out_room = !r_out_valid || i_out_ready;
    assign divisor  = (r_decay_period == 32'd0) ? 32'd1 : r_decay_period;

    mrtu_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_elapsed),
        .i_divisor   (divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Byte to transmit at the current frame index.
    always_comb begin
        tx_is_crc_lo = r_tx_crc_tail && (r_tx_idx == r_tx_len - 4'd2);
        tx_is_crc_hi = r_tx_crc_tail && (r_tx_idx == r_tx_len - 4'd1);
        tx_data_byte = 8'h00;
        if (r_tx_start) begin
            case (r_tx_idx)
                4'd0:    tx_data_byte = r_device_id;
                4'd1:    tx_data_byte = r_act_fc;
                4'd2:    tx_data_byte = r_act_addr[15:8];
                4'd3:    tx_data_byte = r_act_addr[7:0];
                4'd4:    tx_data_byte = r_tx_single ? r_in_val[15:8] : 8'h00;
                4'd5:    tx_data_byte = r_tx_single ? r_in_val[7:0] : {2'b00, r_act_cnt};
                default: tx_data_byte = {1'b0, r_act_cnt, 1'b0};
            endcase
        end else begin
            tx_data_byte = (r_tx_idx == 4'd0) ? r_in_val[15:8] : r_in_val[7:0];
        end
        tx_byte = tx_is_crc_lo ? r_tx_crc[7:0] :
                  tx_is_crc_hi ? r_tx_crc[15:8] : tx_data_byte;
    end

    // Response byte position checks.
    always_comb begin
        rx_rd    = (r_phase == mrtu_pkg::PH_AWAIT_READ);
        rx_len   = rx_rd ? (7'({r_act_cnt, 1'b0}) + 7'd5) : 7'd8;
        rx_pos2  = r_rx_pos + 7'd2;
        rx_mid   = rx_pos2 < rx_len;
        rx_crclo = rx_pos2 == rx_len;
        rx_final = !rx_mid && !rx_crclo;
        rx_off   = r_rx_pos - 7'd3;
        rx_hdr_bad = 1'b0;
        if (r_rx_pos == 7'd0 && r_in_rb != r_device_id) rx_hdr_bad = 1'b1;
        if (r_rx_pos == 7'd1 && r_in_rb != r_act_fc) rx_hdr_bad = 1'b1;
        if (rx_rd) begin
            if (r_rx_pos == 7'd2 && r_in_rb != {1'b0, r_act_cnt, 1'b0}) rx_hdr_bad = 1'b1;
        end else begin
            if (r_rx_pos == 7'd2 && r_in_rb != r_act_addr[15:8]) rx_hdr_bad = 1'b1;
            if (r_rx_pos == 7'd3 && r_in_rb != r_act_addr[7:0]) rx_hdr_bad = 1'b1;
        end
        rx_final_good = rx_final && r_rx_ok && (r_in_rb == r_rx_crc[15:8]);
    end

    // Decay step with the quotient saturated to the counter range.
    always_comb begin
        k_sat  = (div_quo[31:16] != 16'd0) ? 16'hFFFF : div_quo[15:0];
        wr_dec = (r_wr_err > k_sat) ? (r_wr_err - k_sat) : 16'd0;
        rd_dec = (r_rd_err > k_sat) ? (r_rd_err - k_sat) : 16'd0;
    end

    // Status to the controller.
    always_comb begin
        o_stat.op            = r_op;
        o_stat.phase         = r_phase;
        o_stat.out_room      = out_room;
        o_stat.tx_final      = (r_tx_idx == r_tx_len - 4'd1);
        o_stat.rx_final_good = rx_final_good;
        o_stat.rx_has_words  = rx_rd && (r_act_cnt != 6'd0);
        o_stat.word_final    = (r_word_idx + 6'd1 == r_act_cnt);
        o_stat.div_done      = div_done;
    end

    // Response word store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rx_take && rx_rd && rx_mid && r_rx_pos >= 7'd3 && rx_off[0]) begin
            mem[rx_off[mrtu_pkg::WORD_IDX_W:1]] <= {r_rx_hi, r_in_rb};
        end
        r_rd_data <= mem[r_word_idx[mrtu_pkg::WORD_IDX_W-1:0]];
    end

    // Input latch and high-byte holding register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_fc   <= i_function_code;
            r_in_addr <= i_register_address;
            r_in_cnt  <= cnt_sat;
            r_in_val  <= i_write_value;
            r_in_rb   <= i_rx_byte;
        end
        if (i_cmd.rx_take && rx_mid && !rx_off[0]) begin
            r_rx_hi <= r_in_rb;
        end
    end

    // Control and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id    <= 8'd1;
            r_decay_period <= 32'd1000;
            r_op           <= mrtu_pkg::OP_READ;
            r_phase        <= mrtu_pkg::PH_IDLE;
            r_act_fc       <= '0;
            r_act_addr     <= '0;
            r_act_cnt      <= '0;
            r_wts          <= '0;
            r_tx_crc       <= mrtu_pkg::CRC_INIT;
            r_rx_crc       <= mrtu_pkg::CRC_INIT;
            r_rx_pos       <= '0;
            r_rx_ok        <= 1'b1;
            r_wr_err       <= '0;
            r_rd_err       <= '0;
            r_elapsed      <= '0;
            r_code         <= mrtu_pkg::ST_OK;
            r_tx_idx       <= '0;
            r_tx_len       <= '0;
            r_tx_crc_tail  <= 1'b0;
            r_tx_start     <= 1'b0;
            r_tx_single    <= 1'b0;
            r_word_idx     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mrtu_pkg::CFG_DEVICE_ID:    r_device_id    <= i_cfg_data[7:0];
                    mrtu_pkg::CFG_DECAY_PERIOD: r_decay_period <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_op <= mrtu_pkg::t_op'(i_operation);
            end

            // Output register fills on any emit and drains when the receiver takes it.
            if (i_cmd.tx_emit || i_cmd.word_emit || i_cmd.status_emit || i_cmd.total_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // New request frame.
            if (i_cmd.start) begin
                r_act_fc    <= r_in_fc;
                r_act_addr  <= r_in_addr;
                r_act_cnt   <= r_in_cnt;
                r_wts       <= r_in_cnt;
                r_tx_crc    <= mrtu_pkg::CRC_INIT;
                r_rx_crc    <= mrtu_pkg::CRC_INIT;
                r_rx_pos    <= '0;
                r_rx_ok     <= 1'b1;
                r_tx_idx    <= '0;
                r_tx_start  <= 1'b1;
                r_tx_single <= (r_op == mrtu_pkg::OP_SWRITE);
                case (r_op)
                    mrtu_pkg::OP_MWRITE: begin
                        if (r_in_cnt == 6'd0) begin
                            r_tx_len      <= 4'd9;
                            r_tx_crc_tail <= 1'b1;
                            r_phase       <= mrtu_pkg::PH_AWAIT_WRITE;
                        end else begin
                            r_tx_len      <= 4'd7;
                            r_tx_crc_tail <= 1'b0;
                            r_phase       <= mrtu_pkg::PH_COLLECT;
                        end
                    end
                    mrtu_pkg::OP_SWRITE: begin
                        r_tx_len      <= 4'd8;
                        r_tx_crc_tail <= 1'b1;
                        r_phase       <= mrtu_pkg::PH_AWAIT_WRITE;
                    end
                    default: begin
                        r_tx_len      <= 4'd8;
                        r_tx_crc_tail <= 1'b1;
                        r_phase       <= mrtu_pkg::PH_AWAIT_READ;
                    end
                endcase
            end

            // One data word of a multiple write.
            if (i_cmd.data_begin) begin
                r_tx_idx   <= '0;
                r_tx_start <= 1'b0;
                r_wts      <= r_wts - 6'd1;
                if (r_wts == 6'd1) begin
                    r_tx_len      <= 4'd4;
                    r_tx_crc_tail <= 1'b1;
                    r_phase       <= mrtu_pkg::PH_AWAIT_WRITE;
                    r_rx_crc      <= mrtu_pkg::CRC_INIT;
                    r_rx_pos      <= '0;
                    r_rx_ok       <= 1'b1;
                end else begin
                    r_tx_len      <= 4'd2;
                    r_tx_crc_tail <= 1'b0;
                end
            end

            // Frame byte out.
            if (i_cmd.tx_emit) begin
                r_tx_idx <= r_tx_idx + 4'd1;
                if (!tx_is_crc_lo && !tx_is_crc_hi) begin
                    r_tx_crc <= mrtu_pkg::crc_byte(r_tx_crc, tx_byte);
                end
                r_kind      <= mrtu_pkg::KIND_TX;
                r_tx_byte   <= tx_byte;
                r_data_word <= '0;
                r_status    <= '0;
                r_total     <= '0;
                r_last      <= (r_tx_idx == r_tx_len - 4'd1);
            end

            // Response byte in.
            if (i_cmd.rx_take) begin
                r_word_idx <= '0;
                r_code     <= mrtu_pkg::ST_OK;
                if (rx_mid) begin
                    if (rx_hdr_bad) r_rx_ok <= 1'b0;
                    r_rx_crc <= mrtu_pkg::crc_byte(r_rx_crc, r_in_rb);
                    r_rx_pos <= r_rx_pos + 7'd1;
                end else if (rx_crclo) begin
                    if (r_in_rb != r_rx_crc[7:0]) r_rx_ok <= 1'b0;
                    r_rx_pos <= r_rx_pos + 7'd1;
                end else if (!rx_final_good) begin
                    r_rx_crc <= mrtu_pkg::CRC_INIT;
                    r_rx_pos <= '0;
                    r_rx_ok  <= 1'b1;
                end
            end

            // Error counters.
            if (i_cmd.bump_wr) begin
                if (r_wr_err != 16'hFFFF) r_wr_err <= r_wr_err + 16'd1;
                r_code <= mrtu_pkg::ST_WRITE_ERR;
            end
            if (i_cmd.bump_rd) begin
                if (r_rd_err != 16'hFFFF) r_rd_err <= r_rd_err + 16'd1;
                r_code <= mrtu_pkg::ST_READ_ERR;
            end

            // Released read word.
            if (i_cmd.word_emit) begin
                r_word_idx  <= r_word_idx + 6'd1;
                r_kind      <= mrtu_pkg::KIND_WORD;
                r_tx_byte   <= '0;
                r_data_word <= r_rd_data;
                r_status    <= '0;
                r_total     <= '0;
                r_last      <= 1'b0;
            end

            // Transaction status ends the transaction.
            if (i_cmd.status_emit) begin
                r_phase     <= mrtu_pkg::PH_IDLE;
                r_kind      <= mrtu_pkg::KIND_STATUS;
                r_tx_byte   <= '0;
                r_data_word <= '0;
                r_status    <= r_code;
                r_total     <= '0;
                r_last      <= 1'b1;
            end

            // Decay result and error total.
            if (i_cmd.total_emit) begin
                r_elapsed   <= div_rem + 32'd1;
                r_wr_err    <= wr_dec;
                r_rd_err    <= rd_dec;
                r_kind      <= mrtu_pkg::KIND_TOTAL;
                r_tx_byte   <= '0;
                r_data_word <= '0;
                r_status    <= '0;
                r_total     <= {1'b0, wr_dec} + {1'b0, rd_dec};
                r_last      <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_tx_byte     = r_tx_byte;
    assign o_data_word   = r_data_word;
    assign o_status      = r_status;
    assign o_error_total = r_total;
    assign o_last        = r_last;

endmodule

`default_nettype wire

@@ test/modbus_rtu_master_framer_tb.sv @@
// Self-checking testbench of the Modbus RTU master framer: request, response and counter checks.
`default_nettype none

module modbus_rtu_master_framer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE_DELAY = 60;

    // Kinds of exchange that the stimulus builds.
    localparam int EX_GOOD      = 0;
    localparam int EX_CORRUPT   = 1;
    localparam int EX_TRUNCATE  = 2;
    localparam int EX_LINK_FAIL = 3;

    typedef struct {
        mrtu_pkg::t_op op;
        logic [7:0]  fc;
        logic [15:0] addr;
        logic [5:0]  cnt;
        logic [15:0] val;
        logic [7:0]  rxb;
    } t_frame_item;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] word;
        logic [1:0]  status;
        logic [16:0] total;
        logic        last;
    } t_link_result;

    // Clock, reset and block ports.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = mrtu_pkg::CFG_DEVICE_ID;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  operation = '0;
    logic [7:0]  function_code = '0;
    logic [15:0] register_address = '0;
    logic [5:0]  register_count = '0;
    logic [15:0] write_value = '0;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] data_word;
    logic [1:0]  status;
    logic [16:0] error_total;
    logic        last;

    // Stimulus and checking bookkeeping.
    t_frame_item  pending_items[$];
    t_frame_item  offered_item;
    t_link_result expected_results[$];
    bit           in_taken = 1'b0;
    bit           quiet_mode = 1'b0;
    bit           hold_request = 1'b0;
    bit           hold_done = 1'b0;
    int           hold_left = 0;
    int           stall_left = 0;
    int           gap_left = 0;
    int           error_count = 0;
    int           cycle_count = 0;
    logic [7:0]   stim_id = 8'd1;

    // Predicted state of the engine.
    logic [7:0]       m_device_id = 8'd1;
    logic [31:0]      m_decay_period = 32'd1000;
    mrtu_pkg::t_phase m_phase = mrtu_pkg::PH_IDLE;
    logic [7:0]       m_function = '0;
    logic [15:0]      m_address = '0;
    logic [5:0]       m_count = '0;
    logic [5:0]       m_words_left = '0;
    logic [15:0]      m_tx_crc = 16'hFFFF;
    logic [15:0]      m_rx_crc = 16'hFFFF;
    int               m_rx_pos = 0;
    bit               m_rx_good = 1'b1;
    logic [15:0]      m_words[mrtu_pkg::MAX_REGISTERS];
    logic [15:0]      m_write_errors = '0;
    logic [15:0]      m_read_errors = '0;
    logic [31:0]      m_decay_elapsed = '0;

    modbus_rtu_master_framer u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_operation        (operation),
        .i_function_code    (function_code),
        .i_register_address (register_address),
        .i_register_count   (register_count),
        .i_write_value      (write_value),
        .i_rx_byte          (rx_byte),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_kind             (kind),
        .o_tx_byte          (tx_byte),
        .o_data_word        (data_word),
        .o_status           (status),
        .o_error_total      (error_total),
        .o_last             (last)
    );

    always #5 i_clk = ~i_clk;

    // Reflected CRC-16 over one byte, polynomial 0xA001.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) c = (c >> 1) ^ 16'hA001;
            else c = c >> 1;
        end
        return c;
    endfunction

    // Mostly short gaps, a few long ones, none in quiet stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_link_result make_result(input logic [1:0] k, input logic [7:0] b,
                                                 input logic [15:0] w, input logic [1:0] s,
                                                 input logic [16:0] t);
        t_link_result r;
        r.kind = k;
        r.tx_byte = b;
        r.word = w;
        r.status = s;
        r.total = t;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic send_frame_byte(input logic [7:0] b);
        m_tx_crc = crc16_update(m_tx_crc, b);
        expected_results.push_back(make_result(mrtu_pkg::KIND_TX, b, '0, '0, '0));
    endtask

    task automatic send_frame_crc();
        expected_results.push_back(make_result(mrtu_pkg::KIND_TX, m_tx_crc[7:0], '0, '0, '0));
        expected_results.push_back(make_result(mrtu_pkg::KIND_TX, m_tx_crc[15:8], '0, '0, '0));
    endtask

    task automatic restart_response();
        m_rx_crc = 16'hFFFF;
        m_rx_pos = 0;
        m_rx_good = 1'b1;
    endtask

    task automatic close_transaction(input logic [1:0] st);
        expected_results.push_back(make_result(mrtu_pkg::KIND_STATUS, '0, '0, st, '0));
        m_phase = mrtu_pkg::PH_IDLE;
    endtask

    // One response byte: header and CRC checks, word capture, release on a good frame.
    task automatic take_response_byte(input logic [7:0] b);
        bit rd;
        int len;
        int idx;
        rd = (m_phase == mrtu_pkg::PH_AWAIT_READ);
        len = rd ? 2 * m_count + 5 : 8;
        if (m_rx_pos + 2 < len) begin
            if (m_rx_pos == 0 && b != m_device_id) m_rx_good = 1'b0;
            if (m_rx_pos == 1 && b != m_function) m_rx_good = 1'b0;
            if (rd) begin
                if (m_rx_pos == 2 && b != 8'(2 * m_count)) m_rx_good = 1'b0;
                if (m_rx_pos >= 3) begin
                    idx = (m_rx_pos - 3) >> 1;
                    if (idx < mrtu_pkg::MAX_REGISTERS) begin
                        if (((m_rx_pos - 3) & 1) == 0) m_words[idx] = {b, 8'h00};
                        else m_words[idx] = m_words[idx] | {8'h00, b};
                    end
                end
            end else begin
                if (m_rx_pos == 2 && b != m_address[15:8]) m_rx_good = 1'b0;
                if (m_rx_pos == 3 && b != m_address[7:0]) m_rx_good = 1'b0;
            end
            m_rx_crc = crc16_update(m_rx_crc, b);
            m_rx_pos++;
        end else if (m_rx_pos + 2 == len) begin
            if (b != m_rx_crc[7:0]) m_rx_good = 1'b0;
            m_rx_pos++;
        end else begin
            if (b != m_rx_crc[15:8]) m_rx_good = 1'b0;
            if (!m_rx_good) begin
                restart_response();
            end else begin
                if (rd) begin
                    for (int i = 0; i < m_count && i < mrtu_pkg::MAX_REGISTERS; i++) begin
                        expected_results.push_back(make_result(mrtu_pkg::KIND_WORD, '0,
                                                               m_words[i], '0, '0));
                    end
                end
                close_transaction(mrtu_pkg::ST_OK);
            end
        end
    endtask

    // Works out the results of one accepted transaction.
    task automatic predict_transaction(input t_frame_item it);
        int          first;
        logic [5:0]  cnt;
        longint      p;
        longint      e;
        longint      k;
        first = expected_results.size();
        cnt = (it.cnt > mrtu_pkg::MAX_REGISTERS) ? 6'(mrtu_pkg::MAX_REGISTERS) : it.cnt;
        case (it.op)
            mrtu_pkg::OP_READ, mrtu_pkg::OP_SWRITE, mrtu_pkg::OP_MWRITE: begin
                if (m_phase == mrtu_pkg::PH_IDLE) begin
                    m_function = it.fc;
                    m_address = it.addr;
                    m_count = cnt;
                    m_tx_crc = 16'hFFFF;
                    restart_response();
                    send_frame_byte(m_device_id);
                    send_frame_byte(it.fc);
                    send_frame_byte(it.addr[15:8]);
                    send_frame_byte(it.addr[7:0]);
                    if (it.op == mrtu_pkg::OP_SWRITE) begin
                        send_frame_byte(it.val[15:8]);
                        send_frame_byte(it.val[7:0]);
                        send_frame_crc();
                        m_phase = mrtu_pkg::PH_AWAIT_WRITE;
                    end else begin
                        send_frame_byte(8'h00);
                        send_frame_byte({2'b00, cnt});
                        if (it.op == mrtu_pkg::OP_READ) begin
                            send_frame_crc();
                            m_phase = mrtu_pkg::PH_AWAIT_READ;
                        end else begin
                            send_frame_byte(8'(2 * cnt));
                            m_words_left = cnt;
                            if (cnt == 0) begin
                                send_frame_crc();
                                m_phase = mrtu_pkg::PH_AWAIT_WRITE;
                            end else begin
                                m_phase = mrtu_pkg::PH_COLLECT;
                            end
                        end
                    end
                end
            end
            mrtu_pkg::OP_DATA: begin
                if (m_phase == mrtu_pkg::PH_COLLECT) begin
                    send_frame_byte(it.val[15:8]);
                    send_frame_byte(it.val[7:0]);
                    if (m_words_left > 0) m_words_left--;
                    if (m_words_left == 0) begin
                        send_frame_crc();
                        m_phase = mrtu_pkg::PH_AWAIT_WRITE;
                        restart_response();
                    end
                end
            end
            mrtu_pkg::OP_RXB: begin
                if (m_phase == mrtu_pkg::PH_AWAIT_READ || m_phase == mrtu_pkg::PH_AWAIT_WRITE)
                    take_response_byte(it.rxb);
            end
            mrtu_pkg::OP_TXFAIL: begin
                if (m_phase != mrtu_pkg::PH_IDLE) begin
                    if (m_write_errors != 16'hFFFF) m_write_errors++;
                    close_transaction(mrtu_pkg::ST_WRITE_ERR);
                end
            end
            mrtu_pkg::OP_TIMEOUT: begin
                if (m_phase == mrtu_pkg::PH_AWAIT_READ || m_phase == mrtu_pkg::PH_AWAIT_WRITE) begin
                    if (m_read_errors != 16'hFFFF) m_read_errors++;
                    close_transaction(mrtu_pkg::ST_READ_ERR);
                end
            end
            default: begin
                p = (m_decay_period == 0) ? 1 : longint'(m_decay_period);
                e = longint'(m_decay_elapsed) + 1;
                k = 0;
                if (e > p) begin
                    k = (e - 1) / p;
                    e -= k * p;
                end
                m_decay_elapsed = 32'(e);
                if (k > 65535) k = 65535;
                m_write_errors = (m_write_errors > k) ? m_write_errors - 16'(k) : 16'd0;
                m_read_errors = (m_read_errors > k) ? m_read_errors - 16'(k) : 16'd0;
                expected_results.push_back(make_result(mrtu_pkg::KIND_TOTAL, '0, '0, '0,
                    {1'b0, m_read_errors} + {1'b0, m_write_errors}));
            end
        endcase
        if (expected_results.size() > first) expected_results[$].last = 1'b1;
    endtask

    // Sender: holds each transaction until accepted, then an optional gap.
    always @(negedge i_clk) begin
        if (in_valid && !in_taken) begin
            // keep offering the same transaction
        end else if (gap_left > 0) begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_items.size() > 0) begin
            offered_item = pending_items.pop_front();
            operation <= offered_item.op;
            function_code <= offered_item.fc;
            register_address <= offered_item.addr;
            register_count <= offered_item.cnt;
            write_value <= offered_item.val;
            rx_byte <= offered_item.rxb;
            in_valid <= 1'b1;
            gap_left <= pick_gap();
        end else begin
            in_valid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // Receiver: random stalls plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            out_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Monitor: predicts on accepted inputs and checks accepted results.
    always @(posedge i_clk) begin
        t_link_result want;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                in_taken = 1'b1;
                predict_transaction(offered_item);
            end
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d tx=%h word=%h st=%0d tot=%0d last=%b",
                             $time, kind, tx_byte, data_word, status, error_total, last);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (kind !== want.kind || tx_byte !== want.tx_byte ||
                        data_word !== want.word || status !== want.status ||
                        error_total !== want.total || last !== want.last) begin
                        $display("%0t: mismatch expected kind=%0d tx=%h word=%h st=%0d tot=%0d last=%b",
                                 $time, want.kind, want.tx_byte, want.word, want.status,
                                 want.total, want.last);
                        $display("%0t:          actual kind=%0d tx=%h word=%h st=%0d tot=%0d last=%b",
                                 $time, kind, tx_byte, data_word, status, error_total, last);
                        error_count++;
                    end
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_frame_item make_item(input mrtu_pkg::t_op op, input logic [7:0] fc,
                                               input logic [15:0] addr, input logic [5:0] cnt,
                                               input logic [15:0] val, input logic [7:0] rxb);
        t_frame_item it;
        it.op = op;
        it.fc = fc;
        it.addr = addr;
        it.cnt = cnt;
        it.val = val;
        it.rxb = rxb;
        return it;
    endfunction

    task automatic queue_simple(input mrtu_pkg::t_op op);
        pending_items.push_back(make_item(op, 8'($urandom), 16'($urandom), 6'($urandom),
                                          16'($urandom), 8'($urandom)));
    endtask

    task automatic queue_rx_byte(input logic [7:0] b);
        pending_items.push_back(make_item(mrtu_pkg::OP_RXB, 8'($urandom), 16'($urandom),
                                          6'($urandom), 16'($urandom), b));
    endtask

    // A full request and its response: a good one, a corrupted one followed by
    // a good one, a truncated one ended by a timeout, or a link failure right
    // after the request.
    task automatic queue_exchange(input mrtu_pkg::t_op op, input logic [5:0] cnt,
                                  input int flavor);
        logic [7:0]  fc;
        logic [15:0] addr;
        logic [15:0] crc;
        logic [7:0]  resp[$];
        int          n;
        int          cut;
        fc = 8'($urandom);
        addr = 16'($urandom);
        n = (cnt > mrtu_pkg::MAX_REGISTERS) ? mrtu_pkg::MAX_REGISTERS : int'(cnt);
        pending_items.push_back(make_item(op, fc, addr, cnt, 16'($urandom), 8'($urandom)));
        if (flavor == EX_LINK_FAIL) begin
            queue_simple(mrtu_pkg::OP_TXFAIL);
            return;
        end
        if (op == mrtu_pkg::OP_MWRITE) begin
            for (int i = 0; i < n; i++) queue_simple(mrtu_pkg::OP_DATA);
        end
        resp.push_back(stim_id);
        resp.push_back(fc);
        if (op == mrtu_pkg::OP_READ) begin
            resp.push_back(8'(2 * n));
            for (int i = 0; i < 2 * n; i++) resp.push_back(8'($urandom));
        end else begin
            resp.push_back(addr[15:8]);
            resp.push_back(addr[7:0]);
            resp.push_back(8'($urandom));
            resp.push_back(8'($urandom));
        end
        crc = 16'hFFFF;
        foreach (resp[i]) crc = crc16_update(crc, resp[i]);
        resp.push_back(crc[7:0]);
        resp.push_back(crc[15:8]);
        if (flavor == EX_CORRUPT) begin
            cut = $urandom_range(0, resp.size() - 1);
            foreach (resp[i]) queue_rx_byte((i == cut) ? resp[i] ^ 8'($urandom_range(1, 255))
                                                       : resp[i]);
        end
        if (flavor == EX_TRUNCATE) begin
            cut = $urandom_range(0, resp.size() - 1);
            for (int i = 0; i < cut; i++) queue_rx_byte(resp[i]);
            queue_simple(mrtu_pkg::OP_TIMEOUT);
        end else begin
            foreach (resp[i]) queue_rx_byte(resp[i]);
        end
    endtask

    function automatic logic [5:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 6'($urandom_range(0, 4));
        if (r < 95) return 6'($urandom_range(5, 31));
        return 6'($urandom_range(32, 63));
    endfunction

    function automatic int pick_flavor();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return EX_GOOD;
        if (r < 8) return EX_CORRUPT;
        if (r == 8) return EX_TRUNCATE;
        return EX_LINK_FAIL;
    endfunction

    // Random traffic: mostly well-formed exchanges, some noise and error events.
    task automatic queue_random_traffic(input int count);
        int start;
        int r;
        start = pending_items.size();
        while (pending_items.size() - start < count) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                queue_exchange(mrtu_pkg::t_op'($urandom_range(0, 2)), pick_count(),
                               pick_flavor());
            end else if (r < 85) begin
                repeat ($urandom_range(1, 3))
                    pending_items.push_back(make_item(mrtu_pkg::t_op'($urandom_range(0, 7)),
                                                      8'($urandom), 16'($urandom),
                                                      6'($urandom), 16'($urandom),
                                                      8'($urandom)));
                queue_simple(mrtu_pkg::OP_TIMEOUT);
                queue_simple(mrtu_pkg::OP_TXFAIL);
            end else begin
                queue_simple(mrtu_pkg::t_op'($urandom_range(5, 7)));
            end
        end
    endtask

    task automatic wait_until_quiet();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_DELAY) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == mrtu_pkg::CFG_DEVICE_ID) begin
            m_device_id = value[7:0];
            stim_id = value[7:0];
        end else begin
            m_decay_period = value;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle-phase events, zero-count frames, a start while busy.
        queue_simple(mrtu_pkg::OP_TICK);
        queue_simple(mrtu_pkg::OP_TXFAIL);
        queue_simple(mrtu_pkg::OP_TIMEOUT);
        queue_simple(mrtu_pkg::OP_RXB);
        queue_simple(mrtu_pkg::OP_DATA);
        queue_exchange(mrtu_pkg::OP_READ, 6'd0, EX_GOOD);
        pending_items.push_back(make_item(mrtu_pkg::OP_READ, 8'h03, 16'hFFFF, 6'd1,
                                          16'h0, 8'h0));
        queue_simple(mrtu_pkg::OP_SWRITE);
        queue_simple(mrtu_pkg::OP_TIMEOUT);
        queue_exchange(mrtu_pkg::OP_MWRITE, 6'd0, EX_GOOD);
        queue_simple(mrtu_pkg::OP_TICK);

        // Defaults after reset, with one long receiver hold-off.
        quiet_mode = 1'b1;
        queue_random_traffic(40);
        wait_until_quiet();
        quiet_mode = 1'b0;
        queue_random_traffic(80);
        hold_request = 1'b1;
        wait_until_quiet();

        // Lowest id, fastest decay.
        write_register(mrtu_pkg::CFG_DEVICE_ID, 32'd0);
        write_register(mrtu_pkg::CFG_DECAY_PERIOD, 32'd1);
        queue_random_traffic(110);
        wait_until_quiet();

        // Highest id, slowest decay.
        write_register(mrtu_pkg::CFG_DEVICE_ID, 32'd255);
        write_register(mrtu_pkg::CFG_DECAY_PERIOD, 32'hFFFF_FFFF);
        queue_random_traffic(110);
        wait_until_quiet();

        // Random id, short decay period.
        write_register(mrtu_pkg::CFG_DEVICE_ID, $urandom_range(0, 255));
        write_register(mrtu_pkg::CFG_DECAY_PERIOD, 32'd3);
        queue_random_traffic(100);
        wait_until_quiet();

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
